// ===== hw/rtl/spoly_pkg.sv =====
// Shared types and constants for the sparse polynomial add/multiply unit.
// Holds the controller state enum and the command/status structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spoly_pkg;

    localparam int IN_EXP_W  = 7;
    localparam int IN_COEF_W = 16;
    localparam int SUM_W     = IN_COEF_W + 1;
    localparam int PROD_W    = 2 * IN_COEF_W;
    localparam int OUT_EXP_W = 8;
    localparam int COEF_W    = 36;

    localparam logic KIND_SUM  = 1'b0;
    localparam logic KIND_PROD = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_EMPTY,
        ST_MUL,
        ST_SCAN,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_beat;
        logic sum_emit;
        logic mul_start;
        logic mul;
        logic scan_read;
        logic append;
        logic accumulate;
        logic next_k;
        logic emit_read;
        logic emit_load;
        logic empty_load;
    } cmd_t;

    typedef struct packed {
        logic coef_zero;
        logic loading_second;
        logic sum_done;
        logic both_nonempty;
        logic k_at_count;
        logic hit;
        logic last_pair;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spoly_dp.sv =====
// Datapath: term stores, merge logic, multiplier, product table memory, output register.
// Depends on spoly_pkg; driven by spoly_ctrl through cmd_t, reports through status_t.
`timescale 1ns / 1ps
`default_nettype none

module spoly_dp
    import spoly_pkg::*;
#(
    parameter int MAX_TERMS = 4,
    parameter int EXP_BITS  = 7
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [IN_EXP_W-1:0]         s_exponent,
    input  logic signed [IN_COEF_W-1:0] s_coefficient,
    input  logic                        m_ready,
    input  cmd_t                        cmd,
    output status_t                     status,
    output logic                        m_valid,
    output logic                        m_result_kind,
    output logic [OUT_EXP_W-1:0]        m_term_exponent,
    output logic signed [COEF_W-1:0]    m_term_coefficient,
    output logic                        m_last_term,
    output logic                        m_capacity_overflow
);

    localparam int CNT_W      = $clog2(MAX_TERMS + 1);
    localparam int IDX_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int PROD_DEPTH = MAX_TERMS * MAX_TERMS;
    localparam int PCNT_W     = $clog2(PROD_DEPTH + 1);
    localparam int PIDX_W     = (PROD_DEPTH > 1) ? $clog2(PROD_DEPTH) : 1;
    localparam int PEXP_W     = EXP_BITS + 1;
    localparam int WORD_W     = PEXP_W + COEF_W;

    // term stores
    logic [EXP_BITS-1:0]         fexp_reg  [MAX_TERMS];
    logic signed [IN_COEF_W-1:0] fcoef_reg [MAX_TERMS];
    logic [EXP_BITS-1:0]         sexp_reg  [MAX_TERMS];
    logic signed [IN_COEF_W-1:0] scoef_reg [MAX_TERMS];

    logic [CNT_W-1:0]  fcnt_reg, fcnt_next, scnt_reg, scnt_next;
    logic [CNT_W-1:0]  a_reg, a_next, b_reg, b_next;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next;
    logic              load2_reg, load2_next, ovf_reg, ovf_next;
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next, k_reg, k_next;
    logic              mv_reg, mv_next;

    logic [PEXP_W-1:0]        pexp_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [WORD_W-1:0] ptab_mem [PROD_DEPTH];
    logic [WORD_W-1:0] rd_reg;

    logic                     kind_reg, last_reg, oflag_reg;
    logic [OUT_EXP_W-1:0]     oexp_reg;
    logic signed [COEF_W-1:0] ocoef_reg;

    // combinational
    logic [EXP_BITS+IN_EXP_W-1:0] in_exp_w;
    logic [EXP_BITS-1:0]          in_exp;
    logic                         coef_zero, wr_first, wr_second;
    logic [IDX_W-1:0]             f_idx, s_idx;
    logic [EXP_BITS-1:0]          f_exp, s_exp, sum_exp_sel;
    logic signed [IN_COEF_W-1:0]  f_coef, s_coef;
    logic                         a_left, b_left, take_first, take_both;
    logic signed [SUM_W-1:0]      f_coef_x, s_coef_x, sum_coef;
    logic signed [COEF_W-1:0]     sum_coef_w, prod_w, rd_coef, acc;
    logic [PEXP_W+OUT_EXP_W-1:0]  sum_exp_w, prod_exp_w;
    logic [PEXP_W-1:0]            rd_exp;
    logic                         i_last, j_last, emit_last, clear_run, out_load;
    logic                         mem_we;
    logic [PIDX_W-1:0]            wr_addr;
    logic [WORD_W-1:0]            wr_word;

    assign in_exp_w  = {{EXP_BITS{1'b0}}, s_exponent};
    assign in_exp    = in_exp_w[EXP_BITS-1:0];
    assign coef_zero = (s_coefficient == '0);
    assign wr_first  = cmd.load_beat && !coef_zero && !load2_reg
                       && (fcnt_reg < CNT_W'(MAX_TERMS));
    assign wr_second = cmd.load_beat && !coef_zero && load2_reg
                       && (scnt_reg < CNT_W'(MAX_TERMS));

    // one read index per store: pair walk while multiplying, merge pointers otherwise
    assign f_idx  = cmd.mul ? i_reg : a_reg[IDX_W-1:0];
    assign s_idx  = cmd.mul ? j_reg : b_reg[IDX_W-1:0];
    assign f_exp  = fexp_reg[f_idx];
    assign f_coef = fcoef_reg[f_idx];
    assign s_exp  = sexp_reg[s_idx];
    assign s_coef = scoef_reg[s_idx];

    // merge step: larger exponent first, equal exponents add
    assign a_left     = (a_reg < fcnt_reg);
    assign b_left     = (b_reg < scnt_reg);
    assign take_both  = a_left && b_left && (f_exp == s_exp);
    assign take_first = a_left && (!b_left || (f_exp > s_exp));
    assign f_coef_x   = {f_coef[IN_COEF_W-1], f_coef};
    assign s_coef_x   = {s_coef[IN_COEF_W-1], s_coef};
    assign sum_coef   = take_both ? (f_coef_x + s_coef_x) : (take_first ? f_coef_x : s_coef_x);
    assign sum_coef_w = {{(COEF_W-SUM_W){sum_coef[SUM_W-1]}}, sum_coef};
    assign sum_exp_sel = (take_first || take_both) ? f_exp : s_exp;
    assign sum_exp_w  = {{(OUT_EXP_W+1){1'b0}}, sum_exp_sel};

    // product table access
    assign rd_exp     = rd_reg[WORD_W-1:COEF_W];
    assign rd_coef    = rd_reg[COEF_W-1:0];
    assign prod_w     = {{(COEF_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc        = rd_coef + prod_w;
    assign prod_exp_w = {{OUT_EXP_W{1'b0}}, rd_exp};

    assign i_last    = ((CNT_W'(i_reg) + CNT_W'(1)) == fcnt_reg);
    assign j_last    = ((CNT_W'(j_reg) + CNT_W'(1)) == scnt_reg);
    assign emit_last = ((k_reg + PCNT_W'(1)) == pcnt_reg);
    assign clear_run = cmd.empty_load || (cmd.emit_load && emit_last);
    assign out_load  = cmd.sum_emit || cmd.emit_load || cmd.empty_load;

    assign mem_we  = cmd.append || cmd.accumulate;
    assign wr_addr = cmd.append ? pcnt_reg[PIDX_W-1:0] : k_reg[PIDX_W-1:0];
    assign wr_word = cmd.append ? {pexp_reg, prod_w} : {rd_exp, acc};

    always_comb begin
        status.coef_zero      = coef_zero;
        status.loading_second = load2_reg;
        status.sum_done       = !a_left && !b_left;
        status.both_nonempty  = (fcnt_reg != '0) && (scnt_reg != '0);
        status.k_at_count     = (k_reg == pcnt_reg);
        status.hit            = (rd_exp == pexp_reg);
        status.last_pair      = i_last && j_last;
        status.emit_last      = emit_last;
        status.out_free       = !mv_reg || m_ready;
    end

    always_comb begin
        fcnt_next  = fcnt_reg;
        scnt_next  = scnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        load2_next = load2_reg;
        ovf_next   = ovf_reg;
        pcnt_next  = pcnt_reg;
        k_next     = k_reg;
        mv_next    = out_load ? 1'b1 : (m_ready ? 1'b0 : mv_reg);

        if (cmd.load_beat) begin
            if (!coef_zero) begin
                if (wr_first) begin
                    fcnt_next = fcnt_reg + CNT_W'(1);
                end else if (wr_second) begin
                    scnt_next = scnt_reg + CNT_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end else if (!load2_reg) begin
                load2_next = 1'b1;
            end
        end
        if (cmd.sum_emit) begin
            a_next = a_reg + CNT_W'(take_first || take_both);
            b_next = b_reg + CNT_W'(!take_first);
        end
        if (cmd.mul_start) begin
            i_next    = '0;
            j_next    = '0;
            pcnt_next = '0;
        end
        if (cmd.mul) begin
            k_next = '0;
        end
        if (cmd.append) begin
            pcnt_next = pcnt_reg + PCNT_W'(1);
        end
        // advance the pair walk, row by row
        if (cmd.append || cmd.accumulate) begin
            k_next = '0;
            if (j_last) begin
                j_next = '0;
                i_next = i_reg + IDX_W'(1);
            end else begin
                j_next = j_reg + IDX_W'(1);
            end
        end
        if (cmd.next_k || (cmd.emit_load && !emit_last)) begin
            k_next = k_reg + PCNT_W'(1);
        end
        if (clear_run) begin
            fcnt_next  = '0;
            scnt_next  = '0;
            a_next     = '0;
            b_next     = '0;
            load2_next = 1'b0;
            ovf_next   = 1'b0;
            pcnt_next  = '0;
            k_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcnt_reg  <= '0;
            scnt_reg  <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            load2_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            pcnt_reg  <= '0;
            k_reg     <= '0;
            mv_reg    <= 1'b0;
        end else begin
            fcnt_reg  <= fcnt_next;
            scnt_reg  <= scnt_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            load2_reg <= load2_next;
            ovf_reg   <= ovf_next;
            pcnt_reg  <= pcnt_next;
            k_reg     <= k_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_first) begin
            fexp_reg[fcnt_reg[IDX_W-1:0]]  <= in_exp;
            fcoef_reg[fcnt_reg[IDX_W-1:0]] <= s_coefficient;
        end
        if (wr_second) begin
            sexp_reg[scnt_reg[IDX_W-1:0]]  <= in_exp;
            scoef_reg[scnt_reg[IDX_W-1:0]] <= s_coefficient;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= PROD_W'(f_coef) * PROD_W'(s_coef);
            pexp_reg <= {1'b0, f_exp} + {1'b0, s_exp};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ptab_mem[wr_addr] <= wr_word;
        end
        if (cmd.scan_read || cmd.emit_read) begin
            rd_reg <= ptab_mem[k_reg[PIDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum_emit) begin
            kind_reg  <= KIND_SUM;
            oexp_reg  <= sum_exp_w[OUT_EXP_W-1:0];
            ocoef_reg <= sum_coef_w;
            last_reg  <= 1'b0;
            oflag_reg <= ovf_reg;
        end else if (cmd.emit_load) begin
            kind_reg  <= KIND_PROD;
            oexp_reg  <= prod_exp_w[OUT_EXP_W-1:0];
            ocoef_reg <= rd_coef;
            last_reg  <= emit_last;
            oflag_reg <= ovf_reg;
        end else if (cmd.empty_load) begin
            kind_reg  <= KIND_PROD;
            oexp_reg  <= '0;
            ocoef_reg <= '0;
            last_reg  <= 1'b1;
            oflag_reg <= ovf_reg;
        end
    end

    assign m_valid             = mv_reg;
    assign m_result_kind       = kind_reg;
    assign m_term_exponent     = oexp_reg;
    assign m_term_coefficient  = ocoef_reg;
    assign m_last_term         = last_reg;
    assign m_capacity_overflow = oflag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/spoly_ctrl.sv =====
// Controller: state machine that sequences loading, merge, pair walk and product drain.
// Depends on spoly_pkg; talks to spoly_dp only through cmd_t and status_t.
`timescale 1ns / 1ps
`default_nettype none

module spoly_ctrl
    import spoly_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  status_t status,
    output cmd_t    cmd,
    output logic    s_ready
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready       = 1'b1;
                cmd.load_beat = s_valid;
                if (s_valid && status.coef_zero && status.loading_second) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (status.sum_done) begin
                    if (status.both_nonempty) begin
                        cmd.mul_start = 1'b1;
                        state_next    = ST_MUL;
                    end else begin
                        state_next = ST_EMPTY;
                    end
                end else if (status.out_free) begin
                    cmd.sum_emit = 1'b1;
                end
            end
            ST_EMPTY: begin
                if (status.out_free) begin
                    cmd.empty_load = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // table walked with no match: append a new entry
                if (status.k_at_count) begin
                    cmd.append = 1'b1;
                    state_next = status.last_pair ? ST_EMIT_RD : ST_MUL;
                end else begin
                    cmd.scan_read = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.hit) begin
                    cmd.accumulate = 1'b1;
                    state_next     = status.last_pair ? ST_EMIT_RD : ST_MUL;
                end else begin
                    cmd.next_k = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT_RD: begin
                cmd.emit_read = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = status.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sparse_polynomial_add_multiply_unit.sv =====
// Top level of the sparse polynomial add/multiply unit.
// Depends on spoly_pkg, spoly_ctrl and spoly_dp.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+-----------
//  s_      | s_valid s_ready s_exponent s_coefficient      | term in
//  m_      | m_valid m_ready m_result_kind m_term_exponent | result out
//          | m_term_coefficient m_last_term                |
//          | m_capacity_overflow                           |
//
// Sequence: term beats are taken first; a run then emits the sum terms and ends the merge,
//   then gives an empty product, or for each of the F*S pairs multiplies and walks the
//   product table entries held through one read port, and then drains the product terms.
// Reset: aresetn empties the term stores and table count and drops a waiting beat.
// Stalls: a full output register with m_ready low holds the run; term beats are taken
//   only between runs, even while the final beat of a run still waits.
`timescale 1ns / 1ps
`default_nettype none

module sparse_polynomial_add_multiply_unit
    import spoly_pkg::*;
#(
    parameter int MAX_TERMS = 4,
    parameter int EXP_BITS  = 7
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [IN_EXP_W-1:0]         s_exponent,
    input  logic signed [IN_COEF_W-1:0] s_coefficient,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_result_kind,
    output logic [OUT_EXP_W-1:0]        m_term_exponent,
    output logic signed [COEF_W-1:0]    m_term_coefficient,
    output logic                        m_last_term,
    output logic                        m_capacity_overflow
);

    cmd_t    cmd;
    status_t status;

    // sequencing: loading, merge, pair walk and table drain
    spoly_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    // storage, arithmetic and the output register
    spoly_dp #(
        .MAX_TERMS (MAX_TERMS),
        .EXP_BITS  (EXP_BITS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_exponent          (s_exponent),
        .s_coefficient       (s_coefficient),
        .m_ready             (m_ready),
        .cmd                 (cmd),
        .status              (status),
        .m_valid             (m_valid),
        .m_result_kind       (m_result_kind),
        .m_term_exponent     (m_term_exponent),
        .m_term_coefficient  (m_term_coefficient),
        .m_last_term         (m_last_term),
        .m_capacity_overflow (m_capacity_overflow)
    );

    // a result beat is loaded only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sum_emit || cmd.emit_load || cmd.empty_load) |-> status.out_free)
        else $error("result beat loaded over a waiting beat");

    // no run work while term beats are being taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.sum_emit || cmd.emit_load || cmd.empty_load
                      || cmd.mul || cmd.append || cmd.accumulate))
        else $error("run command issued while loading terms");

    // the final product beat reopens the input channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_load && status.emit_last) |=> (s_ready && m_valid && m_last_term))
        else $error("run did not close after its final beat");

endmodule

`default_nettype wire
